>>> rtl/mec_pkg.sv
// Package for the multichannel EMA calibrator: register indexes, widths, item types.
// No dependencies.
package mec_pkg;

   localparam int unsigned AVG_W  = 28;
   localparam int unsigned CSR_W  = 64;
   localparam int unsigned CIDX_W = 3;

   localparam logic [CIDX_W-1:0] REG_ENABLE  = 3'd0;
   localparam logic [CIDX_W-1:0] REG_ORDERS  = 3'd1;
   localparam logic [CIDX_W-1:0] REG_ZERO_LO = 3'd2;
   localparam logic [CIDX_W-1:0] REG_ZERO_HI = 3'd3;
   localparam logic [CIDX_W-1:0] REG_GAIN_LO = 3'd4;
   localparam logic [CIDX_W-1:0] REG_GAIN_HI = 3'd5;

   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_REPORT = 1'b1;

   typedef struct packed {
      logic        action;
      logic [2:0]  channel;
      logic [11:0] sample;
   } req_item_type;

   typedef struct packed {
      logic               [2:0]  out_channel;
      logic signed        [31:0] value;
      logic                      last;
   } rsp_item_type;

endpackage

>>> rtl/mec_req_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on mec_pkg.
interface mec_req_if import mec_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface mec_rsp_if import mec_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/multichannel_ema_calibrator_core.sv
// Top level of the multichannel EMA calibrator.
// Depends on mec_pkg and the channel interfaces in mec_req_if.sv.
//
// One item at a time. A sample item for an enabled channel reads that channel's
// average from an 8-entry synchronous RAM, forms avg*(N-1)+sample<<16 (36 bits),
// and divides it by N with a restoring divider, one quotient bit per cycle; the
// steps are accept, read, setup, the divide and the write-back. A sample for a
// disabled channel is accepted and dropped. A report item walks the channels
// 0..7: a channel that is not reported costs only a scan step; each enabled
// channel takes a scan step, a RAM read, a 16x29 signed multiply, a
// shift/saturate and the handoff to the output register, which waits while that
// register is full and the consumer holds rsp_ready low. Averages reset to zero
// through a valid bit per entry, so no clearing pass is needed after reset.
module multichannel_ema_calibrator_core
   import mec_pkg::*;
#(
   parameter int unsigned CHANNELS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   mec_req_if.sink               req,
   mec_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic [CIDX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_SRD, S_MUL, S_DIV, S_WR,
      S_SCAN, S_RRD, S_RMUL, S_RSAT, S_OUT
   } state_type;

   localparam int unsigned NUM_W = 36;

   // configuration
   logic [7:0]  enable_ff;
   logic [63:0] orders_ff;
   logic [47:0] zero_lo_ff, zero_hi_ff;
   logic [63:0] gain_lo_ff, gain_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= '0;
         orders_ff  <= 64'h0101010101010101;
         zero_lo_ff <= '0;
         zero_hi_ff <= '0;
         gain_lo_ff <= 64'h1000100010001000;
         gain_hi_ff <= 64'h1000100010001000;
      end else if (csr_we) begin
         case (csr_index)
            REG_ENABLE:  enable_ff  <= csr_wdata[7:0];
            REG_ORDERS:  orders_ff  <= csr_wdata;
            REG_ZERO_LO: zero_lo_ff <= csr_wdata[47:0];
            REG_ZERO_HI: zero_hi_ff <= csr_wdata[47:0];
            REG_GAIN_LO: gain_lo_ff <= csr_wdata;
            REG_GAIN_HI: gain_hi_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // average RAM plus per-entry valid bits (invalid reads as zero)
   logic [AVG_W-1:0] avg_mem [8];
   logic [7:0]       avg_vld_ff;
   logic [AVG_W-1:0] rd_data_ff;
   logic             rd_vld_ff;
   logic [2:0]       rd_addr;
   logic             mem_we;
   logic [AVG_W-1:0] mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) avg_mem[rd_addr] <= mem_wdata;
      rd_data_ff <= avg_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (mem_we) avg_vld_ff[rd_addr] <= 1'b1;
         rd_vld_ff <= avg_vld_ff[rd_addr];
      end
   end

   wire [AVG_W-1:0] avg_rd = rd_vld_ff ? rd_data_ff : '0;

   // control and datapath registers
   state_type        state_ff;
   logic [2:0]       chan_ff;
   logic [11:0]      sample_ff;
   logic [7:0]       n_ff;
   logic [NUM_W-1:0] num_ff;      // dividend, shifted out into quotient
   logic [7:0]       rem_ff;
   logic [5:0]       cnt_ff;
   logic signed [45:0] prod_ff;
   logic             rsp_valid_ff;
   rsp_item_type     rsp_ff;
   logic             found_ff;    // a later enabled channel exists

   function automatic logic active(input logic [7:0] en, input logic [2:0] c);
      return (32'(c) < CHANNELS) && en[c];
   endfunction

   wire [7:0] order_raw = orders_ff[8*chan_ff +: 8];
   wire [7:0] order_n   = (order_raw == 8'd0) ? 8'd1 : order_raw;
   wire [11:0] zero_c   = chan_ff[2] ? zero_hi_ff[12*chan_ff[1:0] +: 12]
                                     : zero_lo_ff[12*chan_ff[1:0] +: 12];
   wire signed [15:0] gain_c = chan_ff[2] ? gain_hi_ff[16*chan_ff[1:0] +: 16]
                                          : gain_lo_ff[16*chan_ff[1:0] +: 16];
   wire signed [28:0] diff = $signed({1'b0, avg_rd}) - $signed({1'b0, zero_c, 16'd0});

   // any enabled channel above chan_ff
   logic more_after;
   always_comb begin
      more_after = 1'b0;
      for (int i = 0; i < 8; i++)
         if (3'(i) > chan_ff && active(enable_ff, 3'(i))) more_after = 1'b1;
   end

   // restoring divider step; remainder stays below N, so 8 bits
   wire [8:0] trial = {rem_ff, num_ff[NUM_W-1]};
   wire       ge    = trial >= {1'b0, n_ff};
   wire [7:0] rem_in = ge ? 8'(trial - {1'b0, n_ff}) : trial[7:0];

   // shift and saturate
   wire signed [33:0] shr = 34'(prod_ff >>> 12);
   wire signed [31:0] sat = (shr > 34'sd2147483647)  ? 32'sh7fffffff :
                            (shr < -34'sd2147483648) ? 32'sh80000000 : 32'(shr);

   assign rd_addr   = chan_ff;
   assign mem_we    = (state_ff == S_WR);
   assign mem_wdata = num_ff[AVG_W-1:0];
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         chan_ff      <= '0;
      end else begin
         // output register empties on accept unless S_OUT refills it this cycle
         if (rsp.ready && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req.valid) begin
               sample_ff <= req.data.sample;
               if (req.data.action == ACT_REPORT) begin
                  chan_ff  <= '0;
                  state_ff <= S_SCAN;
               end else begin
                  chan_ff <= req.data.channel;
                  if (active(enable_ff, req.data.channel)) state_ff <= S_SRD;
               end
            end
            S_SRD: begin  // read data arrives next cycle
               n_ff     <= order_n;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               num_ff   <= 36'(avg_rd) * 36'(n_ff - 8'd1) + {8'd0, sample_ff, 16'd0};
               rem_ff   <= '0;
               cnt_ff   <= 6'(NUM_W);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_ff <= rem_in;
               num_ff <= {num_ff[NUM_W-2:0], ge};
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) state_ff <= S_WR;
            end
            S_WR: state_ff <= S_IDLE;
            S_SCAN: begin
               if (active(enable_ff, chan_ff)) state_ff <= S_RRD;
               else if (chan_ff == 3'd7) state_ff <= S_IDLE;
               else chan_ff <= chan_ff + 3'd1;
            end
            S_RRD: state_ff <= S_RMUL;
            S_RMUL: begin
               prod_ff  <= 46'(diff) * 46'(gain_c);
               found_ff <= more_after;
               state_ff <= S_RSAT;
            end
            S_RSAT: state_ff <= S_OUT;
            S_OUT: if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_ff        <= 1'b1;
               rsp_ff.out_channel  <= chan_ff;
               rsp_ff.value        <= sat;
               rsp_ff.last         <= !found_ff;
               if (!found_ff) state_ff <= S_IDLE;
               else begin
                  chan_ff  <= chan_ff + 3'd1;
                  state_ff <= S_SCAN;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // assertions
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready) else $error("ready while busy");
   a_write_only_after_div: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> $past(state_ff) == S_DIV) else $error("stray average write");
   a_out_enabled: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> enable_ff[rsp_ff.out_channel])
      else $error("result for disabled channel");

endmodule
